[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL, clocked on i_clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sgdlr_pkg.sv]
// Package with the types, constants and arithmetic helpers of the SGD regression trainer.
package sgdlr_pkg;

    localparam int COEF_FRAC_BITS   = 16;
    localparam int SAMPLE_FRAC_BITS = 8;
    localparam int LR_FRAC_BITS     = 16;

    localparam int COEF_W    = 32;
    localparam int SAMPLE_W  = 16;
    localparam int LR_W      = 16;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MULT_B_W  = SAMPLE_W + 1;
    localparam int MULT_W    = COEF_W + MULT_B_W;
    localparam int SUM_W     = MULT_W + 1;

    localparam int ALIGN_UP = (COEF_FRAC_BITS >= SAMPLE_FRAC_BITS) ?
                              (COEF_FRAC_BITS - SAMPLE_FRAC_BITS) : 0;
    localparam int ALIGN_DN = (COEF_FRAC_BITS >= SAMPLE_FRAC_BITS) ?
                              0 : (SAMPLE_FRAC_BITS - COEF_FRAC_BITS);

    localparam logic [LR_W-1:0] LR_RESET = LR_W'(655);

    localparam logic [OP_W-1:0] OP_TRAIN   = 2'd0;
    localparam logic [OP_W-1:0] OP_PREDICT = 2'd1;
    localparam logic [OP_W-1:0] OP_RELOAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_BIAS   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DLR,
        ST_CR,
        ST_CRX,
        ST_DONE
    } t_ctrl_state;

    typedef enum logic [1:0] {
        MUL_WX,
        MUL_DLR,
        MUL_CRX
    } t_mul_sel;

    typedef struct packed {
        logic     load_item;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     eval_en;
        logic     cr_en;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic op_train;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic                     sat;
        logic signed [COEF_W-1:0] val;
    } t_clip;

    // Right shift that rounds to nearest, ties toward plus infinity.
    function automatic logic signed [SUM_W-1:0] rnd_shift(input logic signed [SUM_W-1:0] v,
                                                          input int unsigned n);
        logic signed [SUM_W-1:0] half;
        half = '0;
        if (n != 0) begin
            half = SUM_W'(1) <<< (n - 1);
        end
        return (v + half) >>> n;
    endfunction

    // Saturate a wide value to the signed coefficient range.
    function automatic t_clip clip_coef(input logic signed [SUM_W-1:0] v);
        t_clip                   c;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(COEF_W-1){1'b1}}});
        lo = ~hi;
        c.sat = 1'b0;
        c.val = v[COEF_W-1:0];
        if (v > hi) begin
            c.sat = 1'b1;
            c.val = hi[COEF_W-1:0];
        end else if (v < lo) begin
            c.sat = 1'b1;
            c.val = lo[COEF_W-1:0];
        end
        return c;
    endfunction

endpackage

[hw/rtl/sgdlr_ctrl.sv]
// Controller state machine that sequences the shared multiplier of the trainer.
module sgdlr_ctrl import sgdlr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = i_sts.op_train ? ST_DLR : ST_DONE;
            end
            ST_DLR:  n_state = ST_CR;
            ST_CR:   n_state = ST_CRX;
            ST_CRX:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_WX;
        case (r_state)
            ST_IDLE: begin
                o_ready         = 1'b1;
                o_cmd.load_item = i_valid;
                o_cmd.mul_en    = i_valid;
                o_cmd.mul_sel   = MUL_WX;
            end
            ST_EVAL: begin
                o_cmd.eval_en = 1'b1;
            end
            ST_DLR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DLR;
            end
            ST_CR: begin
                o_cmd.cr_en = 1'b1;
            end
            ST_CRX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_CRX;
            end
            ST_DONE: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/sgdlr_dp.sv]
// Datapath with the model state, configuration registers, shared multiplier and output register.
module sgdlr_dp import sgdlr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [COEF_W-1:0]          i_cfg_data,
    input  logic [OP_W-1:0]            i_opcode,
    input  logic signed [SAMPLE_W-1:0] i_sample_x,
    input  logic signed [SAMPLE_W-1:0] i_reference_y,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    input  logic                       i_ready,
    output logic                       o_valid,
    output logic signed [COEF_W-1:0]   o_prediction,
    output logic signed [COEF_W-1:0]   o_weight_out,
    output logic signed [COEF_W-1:0]   o_bias_out,
    output logic                       o_saturated
);

    logic [LR_W-1:0]            r_lr;
    logic signed [COEF_W-1:0]   r_init_w;
    logic signed [COEF_W-1:0]   r_init_b;
    logic signed [COEF_W-1:0]   r_weight;
    logic signed [COEF_W-1:0]   r_bias;
    logic [OP_W-1:0]            r_op;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;
    logic signed [MULT_W-1:0]   r_prod;
    logic signed [COEF_W-1:0]   r_pred;
    logic signed [COEF_W-1:0]   r_dev;
    logic signed [COEF_W-1:0]   r_cr;
    logic                       r_sat;
    logic                       r_out_valid;
    logic signed [COEF_W-1:0]   r_o_pred;
    logic signed [COEF_W-1:0]   r_o_w;
    logic signed [COEF_W-1:0]   r_o_b;
    logic                       r_o_sat;

    logic signed [COEF_W-1:0]   mul_a;
    logic signed [MULT_B_W-1:0] mul_b;
    logic signed [MULT_W-1:0]   mul_p;
    logic signed [SUM_W-1:0]    prod_ext;
    logic signed [SUM_W-1:0]    p_wide;
    logic signed [SUM_W-1:0]    y_al;
    logic signed [SUM_W-1:0]    cr_wide;
    logic signed [SUM_W-1:0]    dw;
    t_clip                      p_clip;
    t_clip                      d_clip;
    t_clip                      w_clip;
    t_clip                      b_clip;
    logic signed [COEF_W-1:0]   n_weight;
    logic signed [COEF_W-1:0]   n_bias;
    logic                       n_sat;
    logic                       out_free;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_WX: begin
                mul_a = r_weight;
                mul_b = MULT_B_W'(i_sample_x);
            end
            MUL_DLR: begin
                mul_a = r_dev;
                mul_b = $signed({1'b0, r_lr});
            end
            MUL_CRX: begin
                mul_a = r_cr;
                mul_b = MULT_B_W'(r_x);
            end
            default: begin
                mul_a = r_weight;
                mul_b = MULT_B_W'(r_x);
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = SUM_W'(r_prod);

    assign p_wide  = rnd_shift(prod_ext, SAMPLE_FRAC_BITS) + SUM_W'(r_bias);
    assign p_clip  = clip_coef(p_wide);
    assign y_al    = rnd_shift(SUM_W'(r_y) <<< ALIGN_UP, ALIGN_DN);
    assign d_clip  = clip_coef(y_al - p_wide);
    assign cr_wide = rnd_shift(prod_ext, LR_FRAC_BITS);
    assign dw      = rnd_shift(prod_ext, SAMPLE_FRAC_BITS);
    assign w_clip  = clip_coef(SUM_W'(r_weight) + dw);
    assign b_clip  = clip_coef(SUM_W'(r_bias) + SUM_W'(r_cr));

    always_comb begin
        case (r_op)
            OP_TRAIN: begin
                n_weight = w_clip.val;
                n_bias   = b_clip.val;
                n_sat    = r_sat | w_clip.sat | b_clip.sat;
            end
            OP_RELOAD: begin
                n_weight = r_init_w;
                n_bias   = r_init_b;
                n_sat    = r_sat;
            end
            default: begin
                n_weight = r_weight;
                n_bias   = r_bias;
                n_sat    = r_sat;
            end
        endcase
    end

    assign out_free       = !r_out_valid || i_ready;
    assign o_sts.out_free = out_free;
    assign o_sts.op_train = (r_op == OP_TRAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr     <= LR_RESET;
            r_init_w <= '0;
            r_init_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEARNING_RATE:  r_lr     <= i_cfg_data[LR_W-1:0];
                REG_INITIAL_WEIGHT: r_init_w <= i_cfg_data;
                REG_INITIAL_BIAS:   r_init_b <= i_cfg_data;
                default:            r_lr     <= r_lr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
            r_bias   <= '0;
        end else if (i_cmd.commit) begin
            r_weight <= n_weight;
            r_bias   <= n_bias;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op <= i_opcode;
            r_x  <= i_sample_x;
            r_y  <= i_reference_y;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_p;
        end
        if (i_cmd.eval_en) begin
            r_pred <= p_clip.val;
            r_dev  <= d_clip.val;
            r_sat  <= p_clip.sat | ((r_op == OP_TRAIN) & d_clip.sat);
        end
        if (i_cmd.cr_en) begin
            r_cr <= cr_wide[COEF_W-1:0];
        end
        if (i_cmd.commit) begin
            r_o_pred <= r_pred;
            r_o_w    <= n_weight;
            r_o_b    <= n_bias;
            r_o_sat  <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_prediction = r_o_pred;
    assign o_weight_out = r_o_w;
    assign o_bias_out   = r_o_b;
    assign o_saturated  = r_o_sat;

endmodule

[hw/rtl/sgd_linear_regression_trainer.sv]
// Top level of the single-feature SGD linear regression trainer.
// A train word passes the states EVAL, DLR, CR and CRX to DONE; a predict or reload word goes from EVAL to DONE.
// One word is in work at a time: a new word is taken only once the last one has left DONE for IDLE.
// The steps are set by the single 32x17 multiplier, used three times in sequence by a train word.
// Synchronous active-low reset clears weight and bias to zero and learning_rate to 655.
`include "assert_macros.svh"
module sgd_linear_regression_trainer import sgdlr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [COEF_W-1:0]          i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [OP_W-1:0]            i_opcode,
    input  logic signed [SAMPLE_W-1:0] i_sample_x,
    input  logic signed [SAMPLE_W-1:0] i_reference_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [COEF_W-1:0]   o_prediction,
    output logic signed [COEF_W-1:0]   o_weight_out,
    output logic signed [COEF_W-1:0]   o_bias_out,
    output logic                       o_saturated
);

    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic [3:0] dp_steps;

    assign dp_steps = {cmd.mul_en, cmd.eval_en, cmd.cr_en, cmd.commit};

    sgdlr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sgdlr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_sample_x    (i_sample_x),
        .i_reference_y (i_reference_y),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_prediction  (o_prediction),
        .o_weight_out  (o_weight_out),
        .o_bias_out    (o_bias_out),
        .o_saturated   (o_saturated)
    );

    `ASSERT_NEXT(a_busy_after_accept, (i_valid && o_ready), (!o_ready), "input taken while busy")
    `ASSERT_HOLDS(a_commit_free, (!cmd.commit || sts.out_free), "result overwrote pending word")
    `ASSERT_NEXT(a_commit_valid, cmd.commit, o_valid, "committed result not presented")
    `ASSERT_HOLDS(a_one_step, ($onehot0(dp_steps)), "overlapping datapath steps")

endmodule

[sim/tb_sgd_linear_regression_trainer.sv]
// Self-checking testbench for the SGD linear regression trainer, with directed and random words.
module tb_sgd_linear_regression_trainer import sgdlr_pkg::*;;

    localparam logic [OP_W-1:0]      OP_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   DRAIN_CYCLES   = 10;

    typedef struct {
        logic signed [COEF_W-1:0] prediction;
        logic signed [COEF_W-1:0] weight;
        logic signed [COEF_W-1:0] bias;
        logic                     saturated;
    } t_fit_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_IDX_W-1:0]       i_cfg_idx;
    logic [COEF_W-1:0]          i_cfg_data;
    logic                       i_valid;
    logic                       o_ready;
    logic [OP_W-1:0]            i_opcode;
    logic signed [SAMPLE_W-1:0] i_sample_x;
    logic signed [SAMPLE_W-1:0] i_reference_y;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [COEF_W-1:0]   o_prediction;
    logic signed [COEF_W-1:0]   o_weight_out;
    logic signed [COEF_W-1:0]   o_bias_out;
    logic                       o_saturated;

    logic signed [COEF_W-1:0] fit_weight;
    logic signed [COEF_W-1:0] fit_bias;
    logic [LR_W-1:0]          rate_reg;
    logic signed [COEF_W-1:0] init_weight_reg;
    logic signed [COEF_W-1:0] init_bias_reg;

    t_fit_result pending_fits[$];
    int          n_errors;
    int          idle_cycles;
    int          stall_left;
    bit          idle_en;

    sgd_linear_regression_trainer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_sample_x    (i_sample_x),
        .i_reference_y (i_reference_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_prediction  (o_prediction),
        .o_weight_out  (o_weight_out),
        .o_bias_out    (o_bias_out),
        .o_saturated   (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint round_shr(input longint v, input int n);
        if (n == 0) begin
            return v;
        end
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [COEF_W-1:0] clamp_coef(input longint v, inout bit flag);
        longint hi;
        longint lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            flag = 1'b1;
            return COEF_W'(hi);
        end
        if (v < lo) begin
            flag = 1'b1;
            return COEF_W'(lo);
        end
        return COEF_W'(v);
    endfunction

    // Applies one word to the regression state and returns the result it must produce.
    function automatic t_fit_result fit_step(input logic [OP_W-1:0] op,
                                             input logic signed [SAMPLE_W-1:0] x,
                                             input logic signed [SAMPLE_W-1:0] y);
        t_fit_result r;
        bit          sat;
        longint      w;
        longint      b;
        longint      p_wide;
        longint      y_al;
        longint      dev;
        longint      step;
        longint      dw;
        sat    = 1'b0;
        w      = longint'(fit_weight);
        b      = longint'(fit_bias);
        p_wide = round_shr(w * longint'(x), SAMPLE_FRAC_BITS) + b;
        r.prediction = clamp_coef(p_wide, sat);
        if (op == OP_TRAIN) begin
            if (COEF_FRAC_BITS >= SAMPLE_FRAC_BITS) begin
                y_al = longint'(y) <<< ALIGN_UP;
            end else begin
                y_al = round_shr(longint'(y), ALIGN_DN);
            end
            dev        = longint'(clamp_coef(y_al - p_wide, sat));
            step       = round_shr(dev * longint'(rate_reg), LR_FRAC_BITS);
            dw         = round_shr(step * longint'(x), SAMPLE_FRAC_BITS);
            fit_bias   = clamp_coef(b + step, sat);
            fit_weight = clamp_coef(w + dw, sat);
        end else if (op == OP_RELOAD) begin
            fit_weight = init_weight_reg;
            fit_bias   = init_bias_reg;
        end
        r.weight    = fit_weight;
        r.bias      = fit_bias;
        r.saturated = sat;
        return r;
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op,
                             input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y);
        int gap;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap     = $urandom_range(1, 3);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_opcode      = op;
        i_sample_x    = x;
        i_reference_y = y;
        do @(posedge i_clk); while (!o_ready);
        pending_fits.push_back(fit_step(op, x, y));
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_fits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_LEARNING_RATE:  rate_reg = data[LR_W-1:0];
            REG_INITIAL_WEIGHT: init_weight_reg = data;
            REG_INITIAL_BIAS:   init_bias_reg = data;
            default: ;
        endcase
    endtask

    task automatic test_reset_state();
        send_word(OP_PREDICT, 16'sh7fff, 16'sh7fff);
        send_word(OP_UNUSED, 16'sh8000, 16'sh8000);
        send_word(OP_PREDICT, 16'sh0000, 16'sh0000);
    endtask

    task automatic test_unknown_register();
        wait_drain();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        send_word(OP_RELOAD, 16'sh1234, 16'sh4321);
        send_word(OP_TRAIN, 16'sh0100, 16'sh0200);
    endtask

    task automatic test_basic_training();
        send_word(OP_TRAIN, 16'sh0100, 16'sh0200);
        send_word(OP_TRAIN, 16'shff00, 16'shfe00);
        send_word(OP_PREDICT, 16'sh0180, 16'sh0000);
    endtask

    task automatic test_saturation();
        wait_drain();
        write_reg(REG_INITIAL_WEIGHT, 32'h7fff_ffff);
        write_reg(REG_INITIAL_BIAS, 32'h7fff_ffff);
        send_word(OP_RELOAD, 16'sh0000, 16'sh0000);
        send_word(OP_PREDICT, 16'sh7fff, 16'sh0000);
        send_word(OP_UNUSED, 16'sh8000, 16'sh7fff);
        wait_drain();
        write_reg(REG_LEARNING_RATE, 32'h0000_ffff);
        send_word(OP_TRAIN, 16'sh8000, 16'sh8000);
        send_word(OP_TRAIN, 16'sh7fff, 16'sh7fff);
        wait_drain();
        write_reg(REG_INITIAL_WEIGHT, 32'h8000_0000);
        write_reg(REG_INITIAL_BIAS, 32'h8000_0000);
        send_word(OP_RELOAD, 16'sh7fff, 16'sh7fff);
        send_word(OP_TRAIN, 16'sh7fff, 16'sh7fff);
        send_word(OP_PREDICT, 16'shffff, 16'sh0000);
    endtask

    task automatic test_zero_rate();
        wait_drain();
        write_reg(REG_LEARNING_RATE, 32'hffff_0000);
        send_word(OP_TRAIN, 16'sh0100, 16'sh7fff);
        send_word(OP_TRAIN, 16'sh8000, 16'sh8000);
    endtask

    // Mostly samples along a noisy line with small x, mixed with full-range noise.
    task automatic test_random_phase(input logic [LR_W-1:0] rate, input logic [COEF_W-1:0] w0,
                                     input logic [COEF_W-1:0] b0, input int count);
        logic [OP_W-1:0]            op;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        longint                     slope;
        longint                     offset;
        longint                     yl;
        int                         pick;
        wait_drain();
        write_reg(REG_LEARNING_RATE, {16'($urandom), rate});
        write_reg(REG_INITIAL_WEIGHT, w0);
        write_reg(REG_INITIAL_BIAS, b0);
        send_word(OP_RELOAD, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        slope  = longint'($urandom_range(0, 1023)) - 512;
        offset = longint'($urandom_range(0, 4095)) - 2048;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                op = OP_TRAIN;
            end else if (pick < 8) begin
                op = OP_PREDICT;
            end else if (pick == 8) begin
                op = OP_RELOAD;
            end else begin
                op = OP_UNUSED;
            end
            if ($urandom_range(0, 3) != 0) begin
                x  = SAMPLE_W'(longint'($urandom_range(0, 2047)) - 1024);
                yl = ((slope * longint'(x)) >>> SAMPLE_FRAC_BITS) + offset
                     + longint'($urandom_range(0, 63)) - 32;
                if (yl > 32767) begin
                    yl = 32767;
                end else if (yl < -32768) begin
                    yl = -32768;
                end
                y = SAMPLE_W'(yl);
            end else begin
                x = SAMPLE_W'($urandom);
                y = SAMPLE_W'($urandom);
            end
            send_word(op, x, y);
        end
    endtask

    task automatic test_random_training();
        idle_en = 1'b1;
        test_random_phase(LR_RESET, 32'h0, 32'h0, 72);
        test_random_phase(16'hffff, 32'h7fff_ffff, 32'h8000_0000, 72);
        test_random_phase(16'h0000, $urandom, $urandom, 72);
        test_random_phase(LR_W'($urandom), 32'h8000_0000, 32'h7fff_ffff, 72);
        test_random_phase(16'h0001, $urandom, $urandom, 72);
        test_random_phase(16'h1000, 32'h0, 32'h0, 72);
        idle_en = 1'b0;
        test_random_phase(LR_W'($urandom_range(1, 8192)), COEF_W'($urandom_range(0, 131071)),
                          32'h0, 72);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready = 1'b0;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_ready    = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_fit_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_fits.size() == 0) begin
                $error("result word with no word pending");
                n_errors++;
            end else begin
                want = pending_fits.pop_front();
                if (o_prediction !== want.prediction) begin
                    $error("prediction: expected %0d, actual %0d", want.prediction, o_prediction);
                    n_errors++;
                end
                if (o_weight_out !== want.weight) begin
                    $error("weight_out: expected %0d, actual %0d", want.weight, o_weight_out);
                    n_errors++;
                end
                if (o_bias_out !== want.bias) begin
                    $error("bias_out: expected %0d, actual %0d", want.bias, o_bias_out);
                    n_errors++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated: expected %0d, actual %0d", want.saturated, o_saturated);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_LEARNING_RATE;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_opcode        = OP_PREDICT;
        i_sample_x      = '0;
        i_reference_y   = '0;
        i_ready         = 1'b1;
        stall_left      = 0;
        idle_en         = 1'b1;
        n_errors        = 0;
        idle_cycles     = 0;
        fit_weight      = '0;
        fit_bias        = '0;
        rate_reg        = LR_RESET;
        init_weight_reg = '0;
        init_bias_reg   = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_unknown_register();
        test_basic_training();
        test_saturation();
        test_zero_rate();
        test_random_training();
        wait_drain();

        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
